// ===== sv/srbr_pkg.sv =====
// Package: shared constants, result struct and PC hash for the replacement engine.
`timescale 1ns / 1ps
`default_nettype none
package srbr_pkg;
    localparam int NUM_SETS_DEF    = 2048;
    localparam int NUM_WAYS_DEF    = 16;
    localparam int LEADER_SETS_DEF = 64;

    localparam int REUSE_N = 4096;
    localparam int REUSE_W = 12;
    localparam int ADDR_W  = 48;
    localparam int SET_IN_W = 11;
    localparam int MASK_W  = 16;

    localparam logic        KIND_VICTIM = 1'b0;
    localparam logic        KIND_UPDATE = 1'b1;

    localparam logic [1:0]  RRPV_MAX    = 2'd3;
    localparam logic [1:0]  RRPV_LONG   = 2'd2;
    localparam logic [1:0]  RRPV_NEAR   = 2'd0;
    localparam logic [1:0]  REUSE_INIT  = 2'd1;
    localparam logic [1:0]  SAT2_MAX    = 2'd3;
    localparam logic [1:0]  CONF_MIN    = 2'd2;
    localparam logic [9:0]  SEL_INIT    = 10'd512;
    localparam logic [9:0]  SEL_MAX     = 10'd1023;
    localparam logic [19:0] DECAY_INIT  = 20'd100000;
    localparam logic [ADDR_W-1:0] STRIDE_A = 48'd64;
    localparam logic [ADDR_W-1:0] STRIDE_B = 48'd128;

    typedef struct packed {
        logic [1:0] score;
        logic [1:0] reuse;
        logic [1:0] rrpv;
        logic       streaming;
        logic [9:0] sel;
        logic [4:0] upd_low;
    } ins_res_t;

    function automatic logic [REUSE_W-1:0] reuse_hash(input logic [ADDR_W-1:0] pc);
        reuse_hash = pc[11:0] ^ pc[24:13] ^ pc[34:23];
    endfunction
endpackage
`default_nettype wire

// ===== sv/srbr_victim.sv =====
// Victim selection and set ageing for one row of re-reference values.
`timescale 1ns / 1ps
`default_nettype none
module srbr_victim
    import srbr_pkg::*;
#(
    parameter int NUM_WAYS = NUM_WAYS_DEF,
    parameter int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1
) (
    input  wire logic [2*NUM_WAYS-1:0] row_in,
    input  wire logic [MASK_W-1:0]     mask,
    output logic [WAY_W-1:0]           way,
    output logic [2*NUM_WAYS-1:0]      row_out
);
    logic [NUM_WAYS-1:0] valid_ext;
    logic [NUM_WAYS-1:0] is3, is2, is1, is3_new;
    logic [1:0] top, add;
    logic       have_free;
    logic [WAY_W-1:0] free_way, aged_way;

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            // ways above the mask width always count as valid
            valid_ext[w] = (w < MASK_W) ? mask[w % MASK_W] : 1'b1;
            is3[w] = row_in[2*w +: 2] == 2'd3;
            is2[w] = row_in[2*w +: 2] == 2'd2;
            is1[w] = row_in[2*w +: 2] == 2'd1;
        end
        have_free = ~&valid_ext;
        free_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
            if (!valid_ext[w]) free_way = WAY_W'(w);

        top = (|is3) ? 2'd3 : (|is2) ? 2'd2 : (|is1) ? 2'd1 : 2'd0;
        add = RRPV_MAX - top;
        for (int w = 0; w < NUM_WAYS; w++) begin
            row_out[2*w +: 2] = row_in[2*w +: 2] + add;
            is3_new[w] = row_out[2*w +: 2] == RRPV_MAX;
        end
        aged_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
            if (is3_new[w]) aged_way = WAY_W'(w);

        if (have_free) begin
            way = free_way;
            row_out = row_in;
        end else begin
            way = aged_way;
        end
    end
endmodule
`default_nettype wire

// ===== sv/srbr_insert.sv =====
// Update path: stride score, reuse training, insertion value and duel selector.
`timescale 1ns / 1ps
`default_nettype none
module srbr_insert
    import srbr_pkg::*;
#(
    parameter int NUM_SETS    = NUM_SETS_DEF,
    parameter int LEADER_SETS = LEADER_SETS_DEF,
    parameter int SET_W       = $clog2(NUM_SETS)
) (
    input  wire logic [SET_W-1:0]  set_idx,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [ADDR_W-1:0] prev_addr,
    input  wire logic [1:0]        score_old,
    input  wire logic [1:0]        reuse_old,
    input  wire logic              hit,
    input  wire logic [4:0]        upd_low_old,
    input  wire logic [9:0]        sel_old,
    output ins_res_t               res
);
    logic [ADDR_W-1:0] delta;
    logic srrip_lead, brrip_lead, pick_srrip, conf;

    always_comb begin
        delta = (addr > prev_addr) ? addr - prev_addr : prev_addr - addr;
        res.upd_low = upd_low_old + 5'd1;

        if (prev_addr == '0)
            res.score = 2'd0;
        else if (delta == STRIDE_A || delta == STRIDE_B)
            res.score = (score_old < SAT2_MAX) ? score_old + 2'd1 : score_old;
        else
            res.score = (score_old != 2'd0) ? score_old - 2'd1 : score_old;
        res.streaming = res.score >= CONF_MIN;

        if (hit)
            res.reuse = (reuse_old < SAT2_MAX) ? reuse_old + 2'd1 : reuse_old;
        else
            res.reuse = (reuse_old != 2'd0) ? reuse_old - 2'd1 : reuse_old;
        conf = res.reuse >= CONF_MIN;

        srrip_lead = 32'(set_idx) < LEADER_SETS;
        brrip_lead = !srrip_lead && (32'(set_idx) + LEADER_SETS >= NUM_SETS);
        pick_srrip = srrip_lead || (!brrip_lead && sel_old >= SEL_INIT);

        if (res.streaming)
            res.rrpv = RRPV_MAX;
        else if (conf)
            res.rrpv = RRPV_NEAR;
        else if (pick_srrip)
            res.rrpv = RRPV_LONG;
        else
            res.rrpv = (res.upd_low == 5'd0) ? RRPV_LONG : RRPV_MAX;

        res.sel = sel_old;
        if (hit && !res.streaming && !conf) begin
            if (srrip_lead) begin
                if (res.rrpv == RRPV_LONG && sel_old < SEL_MAX) res.sel = sel_old + 10'd1;
            end else if (brrip_lead) begin
                if ((res.rrpv == RRPV_LONG || res.rrpv == RRPV_MAX) && sel_old != 10'd0)
                    res.sel = sel_old - 10'd1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/ship_rrip_stream_bypass_replacer.sv =====
// Top level: request sequencer and state memories of the RRIP replacement engine.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata request fields, s_tuser kind
//  m_      | out | m_tvalid/m_tready  | m_tdata way, rrpv, streaming flag
//  cfg_    | in  | cfg_we             | cfg_wdata decay period
//
// For each request the accept edge reads the row, set and reuse memories;
// the lookup state writes back the row memory (for an update also the set
// and reuse memories) and loads the output register. An update that ends a
// decay period starts a walk over the reuse table (one read-modify-write a
// cycle). After reset a clearing pass runs before the first request is taken.
// A waiting result holds the lookup stage until m_tready.
`timescale 1ns / 1ps
`default_nettype none
module ship_rrip_stream_bypass_replacer
    import srbr_pkg::*;
#(
    parameter int NUM_SETS    = NUM_SETS_DEF,
    parameter int NUM_WAYS    = NUM_WAYS_DEF,
    parameter int LEADER_SETS = LEADER_SETS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // set_index[10:0] way_index[14:11] valid_mask[30:15] phys_addr[78:31]
    // pc_value[126:79] was_hit[127]
    input  wire logic [127:0] s_tdata,
    // kind[0]
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // victim_way[3:0] inserted_rrpv[5:4] streaming_flag[6] zero[7]
    output logic [7:0]        m_tdata,
    input  wire logic         cfg_we,
    input  wire logic [19:0]  cfg_wdata
);
    localparam int SET_W = $clog2(NUM_SETS);
    localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int ROW_W = 2 * NUM_WAYS;
    localparam int CLR_N = (NUM_SETS > REUSE_N) ? NUM_SETS : REUSE_N;
    localparam int CLR_W = $clog2(CLR_N) + 1;
    localparam int DEC_W = REUSE_W + 1;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOK, ST_DECAY} state_t;

    logic [ROW_W-1:0]    row_mem   [NUM_SETS];
    logic [ADDR_W+1:0]   set_mem   [NUM_SETS];
    logic [1:0]          reuse_mem [REUSE_N];

    state_t state_reg, state_next;
    logic [CLR_W-1:0] clr_reg, clr_next;
    logic [DEC_W-1:0] dec_reg, dec_next;
    logic [9:0]  sel_reg, sel_next;
    logic [4:0]  upd_low_reg, upd_low_next;
    logic [19:0] countdown_reg, countdown_next;
    logic [19:0] period_reg;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_data_reg, m_data_next;

    logic              kind_reg;
    logic [SET_W-1:0]  set_reg;
    logic [WAY_W-1:0]  way_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [REUSE_W-1:0] hash_reg;
    logic              hit_reg;

    logic [ROW_W-1:0]  row_rd_reg;
    logic [ADDR_W+1:0] set_rd_reg;
    logic [1:0]        reuse_rd_reg;

    logic accept;
    logic [SET_W+SET_IN_W-1:0] set_ext;
    logic [SET_W-1:0]  s_set;
    logic [WAY_W-1:0]  s_way;
    logic [REUSE_W-1:0] s_hash;

    logic              row_we, set_we, reuse_we, reuse_re;
    logic [SET_W-1:0]  row_wa;
    logic [ROW_W-1:0]  row_wd;
    logic [ADDR_W+1:0] set_wd;
    logic [REUSE_W-1:0] reuse_wa, reuse_ra;
    logic [1:0]        reuse_wd;

    logic [WAY_W-1:0]  vic_way;
    logic [ROW_W-1:0]  vic_row;
    logic [WAY_W+3:0]  vic_ext;
    ins_res_t          ins;
    logic [ROW_W-1:0]  upd_row;
    logic [19:0]       cd_inc;
    logic              proceed;

    function automatic logic [WAY_W-1:0] way_mod(input logic [3:0] w);
        way_mod = '0;
        for (int k = 0; k < 16; k++)
            if (w == 4'(k)) way_mod = WAY_W'(k % NUM_WAYS);
    endfunction

    assign s_tready = state_reg == ST_IDLE;
    assign accept   = s_tvalid && s_tready;
    assign set_ext  = {{SET_W{1'b0}}, s_tdata[10:0]};
    assign s_set    = set_ext[SET_W-1:0];
    assign s_way    = way_mod(s_tdata[14:11]);
    assign s_hash   = reuse_hash(s_tdata[126:79]);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    srbr_victim #(.NUM_WAYS(NUM_WAYS), .WAY_W(WAY_W)) u_victim (
        .row_in (row_rd_reg),
        .mask   (mask_reg),
        .way    (vic_way),
        .row_out(vic_row)
    );

    srbr_insert #(.NUM_SETS(NUM_SETS), .LEADER_SETS(LEADER_SETS), .SET_W(SET_W)) u_insert (
        .set_idx    (set_reg),
        .addr       (addr_reg),
        .prev_addr  (set_rd_reg[ADDR_W+1:2]),
        .score_old  (set_rd_reg[1:0]),
        .reuse_old  (reuse_rd_reg),
        .hit        (hit_reg),
        .upd_low_old(upd_low_reg),
        .sel_old    (sel_reg),
        .res        (ins)
    );

    always_comb begin
        upd_row = row_rd_reg;
        upd_row[2*way_reg +: 2] = ins.rrpv;
        vic_ext = {4'd0, vic_way};
        cd_inc  = countdown_reg + 20'd1;
        proceed = !m_valid_reg || m_tready;

        state_next     = state_reg;
        clr_next       = clr_reg;
        dec_next       = dec_reg;
        sel_next       = sel_reg;
        upd_low_next   = upd_low_reg;
        countdown_next = countdown_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;

        row_we   = 1'b0;
        set_we   = 1'b0;
        reuse_we = 1'b0;
        row_wa   = set_reg;
        row_wd   = vic_row;
        set_wd   = {addr_reg, ins.score};
        reuse_wa = hash_reg;
        reuse_wd = ins.reuse;
        reuse_re = accept;
        reuse_ra = s_hash;

        unique case (state_reg)
            ST_CLEAR: begin
                row_wa   = clr_reg[SET_W-1:0];
                row_wd   = '1;
                set_wd   = '0;
                reuse_wa = clr_reg[REUSE_W-1:0];
                reuse_wd = REUSE_INIT;
                row_we   = 32'(clr_reg) < NUM_SETS;
                set_we   = row_we;
                reuse_we = 32'(clr_reg) < REUSE_N;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == CLR_N - 1) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) state_next = ST_LOOK;
            end
            ST_LOOK: begin
                if (proceed) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (kind_reg == KIND_VICTIM) begin
                        row_we      = 1'b1;
                        m_data_next = {1'b0, set_rd_reg[1:0] >= CONF_MIN, 2'b00,
                                       vic_ext[3:0]};
                    end else begin
                        row_we       = 1'b1;
                        row_wd       = upd_row;
                        set_we       = 1'b1;
                        reuse_we     = 1'b1;
                        sel_next     = ins.sel;
                        upd_low_next = ins.upd_low;
                        m_data_next  = {1'b0, ins.streaming, ins.rrpv, 4'd0};
                        if (cd_inc >= period_reg) begin
                            countdown_next = '0;
                            dec_next       = '0;
                            state_next     = ST_DECAY;
                        end else begin
                            countdown_next = cd_inc;
                        end
                    end
                end
            end
            ST_DECAY: begin
                // read entry dec_reg, write back entry dec_reg-1 from the value read the cycle before
                reuse_re = 32'(dec_reg) < REUSE_N;
                reuse_ra = dec_reg[REUSE_W-1:0];
                reuse_we = dec_reg != '0;
                reuse_wa = REUSE_W'(dec_reg - 1'b1);
                reuse_wd = (reuse_rd_reg != 2'd0) ? reuse_rd_reg - 2'd1 : reuse_rd_reg;
                dec_next = dec_reg + 1'b1;
                if (32'(dec_reg) == REUSE_N) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            dec_reg       <= '0;
            sel_reg       <= SEL_INIT;
            upd_low_reg   <= '0;
            countdown_reg <= '0;
            period_reg    <= DECAY_INIT;
            m_valid_reg   <= 1'b0;
            m_data_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            dec_reg       <= dec_next;
            sel_reg       <= sel_next;
            upd_low_reg   <= upd_low_next;
            countdown_reg <= countdown_next;
            m_valid_reg   <= m_valid_next;
            m_data_reg    <= m_data_next;
            if (cfg_we) period_reg <= cfg_wdata;
        end
    end

    // request capture, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= s_tuser;
            set_reg  <= s_set;
            way_reg  <= s_way;
            mask_reg <= s_tdata[30:15];
            addr_reg <= s_tdata[78:31];
            hash_reg <= s_hash;
            hit_reg  <= s_tdata[127];
        end
    end

    always_ff @(posedge aclk) begin
        if (row_we) row_mem[row_wa] <= row_wd;
        if (accept) row_rd_reg <= row_mem[s_set];
    end

    always_ff @(posedge aclk) begin
        if (set_we) set_mem[row_wa] <= set_wd;
        if (accept) set_rd_reg <= set_mem[s_set];
    end

    always_ff @(posedge aclk) begin
        if (reuse_we) reuse_mem[reuse_wa] <= reuse_wd;
        if (reuse_re) reuse_rd_reg <= reuse_mem[reuse_ra];
    end
endmodule
`default_nettype wire

// ===== tb/ship_rrip_stream_bypass_replacer_tb.sv =====
// Testbench: directed and randomised streaming check of the RRIP replacement engine against a local predictor.
`timescale 1ns / 1ps
`default_nettype none
module ship_rrip_stream_bypass_replacer_tb;
    import srbr_pkg::*;

    localparam int SETS    = 2048;
    localparam int WAYS    = 16;
    localparam int LEADERS = 64;
    localparam int WDOG_LIMIT = 200000;
    localparam int HOLD_LEN   = 400;

    typedef struct packed {
        logic        kind;
        logic [10:0] set_index;
        logic [3:0]  way_index;
        logic [15:0] valid_mask;
        logic [47:0] phys_addr;
        logic [47:0] pc_value;
        logic        was_hit;
    } req_t;

    typedef struct packed {
        logic [3:0] way;
        logic [1:0] rrpv;
        logic       strm;
    } outcome_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [7:0]   m_tdata;
    logic         cfg_we = 1'b0;
    logic [19:0]  cfg_wdata = '0;

    ship_rrip_stream_bypass_replacer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // predictor state
    logic [1:0]  rrpv_mem [SETS*WAYS];
    logic [1:0]  reuse_mem [REUSE_N];
    logic [47:0] prev_addr_mem [SETS];
    logic [1:0]  stride_score [SETS];
    logic [9:0]  duel_sel;
    logic [4:0]  upd_low;
    logic [19:0] decay_cnt;
    logic [19:0] decay_len;

    req_t     pending_reqs [$];
    outcome_t expected_outcomes [$];
    int       mismatches = 0;
    int       n_victims = 0, n_updates = 0, n_stream = 0;
    int       idle_cycles = 0;
    int       hold_reqs = 0, hold_seen = 0, hold_left = 0;

    function automatic logic [11:0] pc_hash(logic [47:0] pc);
        logic [47:0] h;
        h = pc ^ (pc >> 13) ^ (pc >> 23);
        return h[11:0];
    endfunction

    task automatic predictor_reset();
        for (int i = 0; i < SETS*WAYS; i++) rrpv_mem[i] = RRPV_MAX;
        for (int i = 0; i < REUSE_N; i++) reuse_mem[i] = REUSE_INIT;
        for (int i = 0; i < SETS; i++) begin
            prev_addr_mem[i] = '0;
            stride_score[i] = '0;
        end
        duel_sel = SEL_INIT;
        upd_low = '0;
        decay_cnt = '0;
        decay_len = DECAY_INIT;
    endtask

    function automatic outcome_t predict(req_t r);
        outcome_t o;
        int s, w, base, top, d;
        logic [47:0] delta;
        logic [11:0] idx;
        logic [1:0] v;
        bit strm, slead, blead, use_s, found;
        s = int'(r.set_index);
        w = int'(r.way_index);
        base = s * WAYS;
        o = '0;
        if (r.kind == KIND_VICTIM) begin
            n_victims++;
            found = 1'b0;
            for (int i = 0; i < WAYS; i++)
                if (!found && !r.valid_mask[i]) begin
                    o.way = 4'(i);
                    found = 1'b1;
                end
            if (!found) begin
                top = 0;
                for (int i = 0; i < WAYS; i++)
                    if (int'(rrpv_mem[base+i]) > top) top = int'(rrpv_mem[base+i]);
                d = 3 - top;
                for (int i = 0; i < WAYS; i++) rrpv_mem[base+i] = rrpv_mem[base+i] + 2'(d);
                for (int i = WAYS-1; i >= 0; i--)
                    if (rrpv_mem[base+i] == RRPV_MAX) o.way = 4'(i);
            end
            o.strm = stride_score[s] >= 2;
            return o;
        end
        n_updates++;
        upd_low++;
        decay_cnt++;
        if (prev_addr_mem[s] == 0) begin
            stride_score[s] = '0;
        end else begin
            delta = (r.phys_addr > prev_addr_mem[s]) ? r.phys_addr - prev_addr_mem[s]
                                                     : prev_addr_mem[s] - r.phys_addr;
            if (delta == STRIDE_A || delta == STRIDE_B) begin
                if (stride_score[s] < 3) stride_score[s]++;
            end else if (stride_score[s] > 0) begin
                stride_score[s]--;
            end
        end
        prev_addr_mem[s] = r.phys_addr;
        strm = stride_score[s] >= 2;
        idx = pc_hash(r.pc_value);
        if (r.was_hit) begin
            if (reuse_mem[idx] < 3) reuse_mem[idx]++;
        end else if (reuse_mem[idx] > 0) begin
            reuse_mem[idx]--;
        end
        slead = s < LEADERS;
        blead = !slead && (s + LEADERS >= SETS);
        use_s = slead ? 1'b1 : blead ? 1'b0 : (duel_sel >= 512);
        if (strm) v = RRPV_MAX;
        else if (reuse_mem[idx] >= CONF_MIN) v = RRPV_NEAR;
        else if (use_s) v = RRPV_LONG;
        else v = (upd_low == 0) ? RRPV_LONG : RRPV_MAX;
        rrpv_mem[base+w] = v;
        if (r.was_hit && !strm && reuse_mem[idx] < CONF_MIN) begin
            if (slead) begin
                if (v == RRPV_LONG && duel_sel < SEL_MAX) duel_sel++;
            end else if (blead) begin
                if (duel_sel > 0) duel_sel--;
            end
        end
        if (decay_cnt >= decay_len) begin
            decay_cnt = '0;
            for (int i = 0; i < REUSE_N; i++)
                if (reuse_mem[i] > 0) reuse_mem[i]--;
        end
        if (strm) n_stream++;
        o.rrpv = v;
        o.strm = strm;
        return o;
    endfunction

    // driver: bursts and gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_outcomes.push_back(predict(pending_reqs.pop_front()));
            end
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {pending_reqs[0].was_hit, pending_reqs[0].pc_value,
                                pending_reqs[0].phys_addr, pending_reqs[0].valid_mask,
                                pending_reqs[0].way_index, pending_reqs[0].set_index};
                    s_tuser <= pending_reqs[0].kind;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 20);
                        if ($urandom_range(0, 3) != 0) gap_left <= $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, with a long hold-off counted here on request
    int stall_phase = 0;
    always @(posedge aclk) begin
        stall_phase <= stall_phase + 1;
        if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_LEN;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if ((stall_phase / 64) % 3 == 0) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // monitor
    always @(posedge aclk) begin
        outcome_t e, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.way = m_tdata[3:0];
            got.rrpv = m_tdata[5:4];
            got.strm = m_tdata[6];
            if (expected_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer: %h", m_tdata);
            end else begin
                e = expected_outcomes.pop_front();
                if (got !== e || m_tdata[7] !== 1'b0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: way %0d/%0d rrpv %0d/%0d strm %0d/%0d (exp/got)",
                                 e.way, got.way, e.rrpv, got.rrpv, e.strm, got.strm);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog expired");
            $display("tb: failure");
            $finish;
        end
    end

    function automatic req_t rand_req(bit kind);
        req_t r;
        r.kind = kind;
        r.set_index = 11'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                    : ($urandom_range(0, 3) == 0) ? $urandom_range(1984, 2047)
                    : $urandom_range(0, 2047));
        r.way_index = 4'($urandom);
        r.valid_mask = ($urandom_range(0, 2) == 0) ? 16'(~(1 << $urandom_range(0, 15)))
                                                   : 16'hFFFF;
        if ($urandom_range(0, 9) == 0) r.valid_mask = 16'($urandom);
        r.phys_addr = 48'({$urandom, $urandom});
        r.pc_value = 48'({$urandom, $urandom});
        r.was_hit = 1'($urandom);
        return r;
    endfunction

    task automatic push(req_t r);
        pending_reqs.push_back(r);
    endtask

    task automatic drain();
        wait (pending_reqs.size() == 0 && !s_tvalid);
        wait (expected_outcomes.size() == 0);
        repeat (REUSE_N + 20) @(posedge aclk);
    endtask

    task automatic write_period(logic [19:0] p);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= p;
        decay_len = p;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // a strided stream in one set, with one repeated PC per run for reuse
    task automatic stream_run(int len);
        req_t r;
        logic [47:0] a;
        logic [47:0] pc;
        r = rand_req(KIND_UPDATE);
        a = 48'({$urandom, $urandom});
        a[5:0] = '0;
        pc = 48'({$urandom_range(0, 7), 12'h0});
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                push(rand_req(KIND_VICTIM));
            end else begin
                a = a + (($urandom_range(0, 5) == 0) ? 48'd4096 : ($urandom_range(0, 1) ? 48'd64
                                                                         : 48'd128));
                r.phys_addr = a;
                r.pc_value = ($urandom_range(0, 1)) ? pc : 48'({$urandom, $urandom});
                r.way_index = 4'($urandom);
                r.was_hit = 1'($urandom);
                push(r);
            end
        end
    endtask

    initial begin
        req_t r;
        logic [19:0] periods [4];
        predictor_reset();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, address zero history, full/empty masks
        r = '0; r.kind = KIND_VICTIM; r.valid_mask = 16'hFFFF; push(r);
        r.valid_mask = 16'h0000; push(r);
        r.valid_mask = 16'h7FFF; r.set_index = 11'h7FF; push(r);
        r = '0; r.kind = KIND_UPDATE; r.set_index = 11'h7FF; r.way_index = 4'hF;
        r.phys_addr = 48'hFFFF_FFFF_FFFF; r.pc_value = 48'hFFFF_FFFF_FFFF; r.was_hit = 1; push(r);
        r.phys_addr = 48'hFFFF_FFFF_FFBF; push(r);
        r.phys_addr = 48'hFFFF_FFFF_FF3F; push(r);
        r.phys_addr = 48'h0; push(r);
        r = '0; r.kind = KIND_UPDATE; r.was_hit = 1; r.phys_addr = 48'h40; push(r);
        r.phys_addr = 48'h80; push(r);
        r.phys_addr = 48'h100; push(r);
        r.was_hit = 0; r.set_index = 11'd1000; r.phys_addr = 48'h1000; push(r);
        r.phys_addr = 48'h1040; push(r);
        r.kind = KIND_VICTIM; r.valid_mask = 16'hFFFF; push(r);
        r.set_index = 11'h7FF; push(r);
        for (int i = 0; i < 6; i++) push(rand_req(KIND_UPDATE));
        drain();

        periods = '{20'd1, 20'd7, 20'hFFFFF, 20'd300};
        for (int ph = 0; ph < 4; ph++) begin
            write_period(periods[ph]);
            for (int k = 0; k < 380; ) begin
                if ($urandom_range(0, 3) != 0) begin
                    stream_run(12);
                    k += 12;
                end else begin
                    push(rand_req(1'($urandom)));
                    k++;
                end
                // long receiver hold-off while queued items keep coming
                if (ph == 1 && k > 100 && hold_reqs == 0) hold_reqs++;
            end
            drain();
        end

        $display("covered %0d victim and %0d update requests, %0d streaming inserts,",
                 n_victims, n_updates, n_stream);
        $display("decay periods 1, 7, 300 and the maximum, and one long output stall");
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
